// ===== sv/round_robin_task_scheduler_core_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RRTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rrts assertion failed");
`define RRTS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rrts reset assertion failed");
`else
`define RRTS_ASSERT(lbl, prop)
`define RRTS_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== sv/rrts_pkg.sv =====
// Types, codes and constants of the round-robin task scheduler.
// No dependencies; used by every module of the block.
package rrts_pkg;

  localparam int MAX_TASKS_DEF = 64;

  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;
  localparam int QUOT_W = 64 - DIV10_SHIFT;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_TICK   = 3'd1,
    OP_YIELD  = 3'd2,
    OP_EXIT   = 3'd3,
    OP_SLEEP  = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_READY    = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_DEAD     = 2'd2
  } task_state_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] sleep_ms;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  task_id;
    logic        error;
    logic [6:0]  task_count;
    logic [31:0] tick_count;
    logic [31:0] wake_tick;
  } out_item_t;

  typedef struct packed {
    logic        mark;
    task_state_t mark_state;
    logic        shift;
    logic        wrap;
    logic        load;
  } cell_ctrl_t;

endpackage

// ===== sv/rrts_cell.sv =====
// One position of the scheduling ring: a task slot number and that task's state.
// Depends on rrts_pkg.
module rrts_cell #(
  parameter int SLOT_W = 6
) (
  input  logic                 clk,
  input  rrts_pkg::cell_ctrl_t ctrl,
  input  logic [SLOT_W-1:0]    mark_slot,
  input  logic [SLOT_W-1:0]    load_slot,
  input  logic [SLOT_W-1:0]    nbr_slot,
  input  rrts_pkg::task_state_t nbr_state,
  input  logic [SLOT_W-1:0]    head_slot,
  input  rrts_pkg::task_state_t head_state,
  output logic [SLOT_W-1:0]    slot_q,
  output rrts_pkg::task_state_t state_q
);
  import rrts_pkg::*;

  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  task_state_t       state_r;
  task_state_t       state_nxt;

  always_comb begin
    slot_nxt  = slot_r;
    state_nxt = state_r;
    priority if (ctrl.load) begin
      slot_nxt  = load_slot;
      state_nxt = ST_READY;
    end else if (ctrl.shift) begin
      slot_nxt  = nbr_slot;
      state_nxt = nbr_state;
    end else if (ctrl.wrap) begin
      slot_nxt  = head_slot;
      state_nxt = head_state;
    end else if (ctrl.mark && (slot_r == mark_slot)) begin
      state_nxt = ctrl.mark_state;
    end else begin
      slot_nxt  = slot_r;
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    state_r <= state_nxt;
  end

  assign slot_q  = slot_r;
  assign state_q = state_r;

endmodule

// ===== sv/round_robin_task_scheduler_core.sv =====
// Top level of the round-robin task scheduler: control, counters and the ring of cells.
// Depends on rrts_pkg, rrts_cell and round_robin_task_scheduler_core_defines.svh.
//
//   Channel  Ports                        Transaction
//   input    in_valid, in_stall, in_data   one operation and its sleep time
//   output   out_valid, out_stall, out_data one result per operation
//
// In the accepting cycle a transaction marks the current task and forms the sleep quotient;
// in the EXEC state the ring of cells rotates or takes a new task, and the result is loaded.
// A new transaction is accepted as soon as the previous one has reached the output register.
// A stalled output holds the EXEC state until the register is free.
// Reset clears all counters at once; there is no clearing pass.
module round_robin_task_scheduler_core #(
  parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rrts_pkg::out_item_t out_data
);
  import rrts_pkg::*;

`include "round_robin_task_scheduler_core_defines.svh"

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  fsm_t              state_r;
  fsm_t              state_nxt;
  logic [2:0]        op_r;
  logic [QUOT_W-1:0] quot_r;
  logic [63:0]       prod;
  logic [CNT_W-1:0]  held_r;
  logic [CNT_W-1:0]  held_nxt;
  logic              run_v_r;
  logic              run_v_nxt;
  logic [SLOT_W-1:0] run_slot_r;
  logic [SLOT_W-1:0] run_slot_nxt;
  logic [31:0]       ticks_r;
  logic [31:0]       ticks_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         result;
  logic              in_accept;
  logic              exec_go;
  logic              mark_go;
  task_state_t       mark_state;
  logic              is_tick;
  logic              is_create;
  logic              rot_go;
  logic              create_go;
  logic [SLOT_W:0]   run_id;

  logic [SLOT_W-1:0] slot_q  [MAX_TASKS];
  task_state_t       state_q [MAX_TASKS];
  cell_ctrl_t        ctrl    [MAX_TASKS];

  assign in_accept = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_accept) state_nxt = FSM_EXEC;
      FSM_EXEC: if (exec_go) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != FSM_IDLE);
    exec_go  = (state_r == FSM_EXEC) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    mark_go    = 1'b0;
    mark_state = ST_READY;
    unique case (op_t'(in_data.operation))
      OP_YIELD: begin
        mark_go    = run_v_r;
        mark_state = ST_READY;
      end
      OP_EXIT: begin
        mark_go    = run_v_r;
        mark_state = ST_DEAD;
      end
      OP_SLEEP: begin
        mark_go    = run_v_r;
        mark_state = ST_SLEEPING;
      end
      default: begin
        mark_go    = 1'b0;
        mark_state = ST_READY;
      end
    endcase
    mark_go = mark_go && in_accept;
  end

  assign prod = 64'(in_data.sleep_ms) * 64'(DIV10_RECIP);

  always_comb begin
    is_tick   = 1'b0;
    is_create = 1'b0;
    unique case (op_t'(op_r))
      OP_CREATE: is_create = 1'b1;
      OP_TICK, OP_YIELD, OP_EXIT, OP_SLEEP: is_tick = 1'b1;
      default: begin
        is_tick   = 1'b0;
        is_create = 1'b0;
      end
    endcase
  end

  assign rot_go    = exec_go && is_tick && (held_r != '0);
  assign create_go = exec_go && is_create && (held_r != CNT_W'(MAX_TASKS));

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [SLOT_W-1:0] nbr_slot;
    task_state_t       nbr_state;

    if (i + 1 < MAX_TASKS) begin : g_nbr
      assign nbr_slot  = slot_q[i+1];
      assign nbr_state = state_q[i+1];
    end else begin : g_last
      assign nbr_slot  = slot_q[i];
      assign nbr_state = state_q[i];
    end

    always_comb begin
      ctrl[i].mark       = mark_go;
      ctrl[i].mark_state = mark_state;
      ctrl[i].shift      = rot_go && (CNT_W'(i + 1) < held_r);
      ctrl[i].wrap       = rot_go && (CNT_W'(i + 1) == held_r);
      ctrl[i].load       = create_go && (CNT_W'(i) == held_r);
    end

    rrts_cell #(
      .SLOT_W(SLOT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .mark_slot (run_slot_r),
      .load_slot (SLOT_W'(held_r)),
      .nbr_slot  (nbr_slot),
      .nbr_state (nbr_state),
      .head_slot (slot_q[0]),
      .head_state(state_q[0]),
      .slot_q    (slot_q[i]),
      .state_q   (state_q[i])
    );
  end

  always_comb begin
    held_nxt     = held_r;
    run_v_nxt    = run_v_r;
    run_slot_nxt = run_slot_r;
    ticks_nxt    = ticks_r;
    result       = '0;
    if (is_tick) begin
      ticks_nxt = ticks_r + 32'd1;
      if ((held_r != '0) && (state_q[0] == ST_READY)) begin
        run_v_nxt    = 1'b1;
        run_slot_nxt = slot_q[0];
      end
    end
    if (is_create && (held_r != CNT_W'(MAX_TASKS))) begin
      held_nxt = held_r + CNT_W'(1);
    end
    run_id = {1'b0, run_slot_nxt} + (SLOT_W + 1)'(1);
    if (is_create) begin
      if (held_r == CNT_W'(MAX_TASKS)) begin
        result.error = 1'b1;
      end else begin
        result.task_id = 7'(held_nxt);
      end
    end else if (run_v_nxt) begin
      result.task_id = 7'(run_id);
    end
    if ((op_t'(op_r) == OP_SLEEP) && run_v_r) begin
      result.wake_tick = ticks_r + 32'(quot_r);
    end
    result.task_count = 7'(held_nxt);
    result.tick_count = ticks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      held_r      <= '0;
      run_v_r     <= 1'b0;
      run_slot_r  <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= exec_go || (out_valid_r && out_stall);
      if (exec_go) begin
        held_r     <= held_nxt;
        run_v_r    <= run_v_nxt;
        run_slot_r <= run_slot_nxt;
        ticks_r    <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_data.operation;
      quot_r <= prod[63:DIV10_SHIFT];
    end
    if (exec_go) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RRTS_ASSERT(a_held_bound, held_r <= CNT_W'(MAX_TASKS))
  `RRTS_ASSERT(a_accept_exec, in_accept |=> (state_r == FSM_EXEC))
  `RRTS_ASSERT(a_out_after_exec, $rose(out_valid_r) |-> $past(state_r == FSM_EXEC))
  `RRTS_ASSERT(a_running_kept, run_v_r |=> run_v_r)
  `RRTS_ASSERT(a_running_in_table, run_v_r |-> (CNT_W'(run_slot_r) < held_r))
  `RRTS_ASSERT_RST(a_reset_out, !rst_n |=> !out_valid_r)

endmodule
